// File: src/grouped_free_block_allocator_core_macros.svh
// Assertion macros shared by the allocator checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef GROUPED_FREE_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define GROUPED_FREE_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GFBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GFBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/gfba_pkg.sv
// Shared types and constants for the grouped free-block allocator.
// No dependencies; used by every module of the block except gfba_ram.
`timescale 1ns / 1ps

package gfba_pkg;

  localparam int unsigned ID_W     = 10;
  localparam int unsigned TDATA_W  = 16;
  localparam logic [ID_W-1:0] END_MARK = 10'd999;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_NONE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TOP,
    S_BASE,
    S_LOAD,
    S_LOAD_END,
    S_SPILL,
    S_SPILL_END,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_ZERO_OK,
    RES_FAIL,
    RES_TOP,
    RES_LINK
  } res_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     latch;
    logic     push;
    logic     pop;
    logic     link_top;
    logic     link_id;
    logic     calc_base;
    logic     seq_clr;
    logic     load_step;
    logic     spill_step;
    logic     spill_fin;
    res_sel_e res_sel;
    logic     out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_free;
    logic cnt_zero;
    logic cnt_one;
    logic cnt_full;
    logic id_bad;
    logic top_bad;
    logic load_last;
    logic spill_last;
    logic out_free;
  } dp_stat_t;

endpackage

// File: src/grouped_free_block_allocator_core.sv
// Channel   Dir  tdata            tuser
// s_axis    in   block_id [9:0]   cmd (0 allocate, 1 free)
// m_axis    out  alloc_id [9:0]   status (0 ok, 1 none free)
//
// Allocate from a non-final stack entry: IDLE, DECODE, TOP, DONE; free with
// room: IDLE, DECODE, DONE. A group load reads GROUP_SIZE+1 words from the
// group RAM, one per cycle; a spill on a full stack writes as many words.
// One request is in work at a time; the output register holds a result while
// m_axis stalls and the next request may be taken meanwhile.
// Reset is asynchronous; no clearing pass is run, the stack starts at once.
`timescale 1ns / 1ps

module grouped_free_block_allocator_core #(
  parameter int unsigned GROUP_SIZE = 250,
  parameter int unsigned NUM_BLOCKS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [gfba_pkg::TDATA_W-1:0]   s_axis_tdata_i,  // [9:0] block_id
  input  logic                           s_axis_tuser_i,  // [0] cmd
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [gfba_pkg::TDATA_W-1:0]   m_axis_tdata_o,  // [9:0] alloc_id
  output logic                           m_axis_tuser_o   // [0] status
);
  import gfba_pkg::*;

  ctrl_cmd_t       cmd;
  dp_stat_t        stat;
  logic [ID_W-1:0] res_id;

  gfba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  gfba_dp #(
    .GROUP_SIZE (GROUP_SIZE),
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_cmd_i    (s_axis_tuser_i),
    .req_id_i     (s_axis_tdata_i[ID_W-1:0]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_id_o     (res_id),
    .res_status_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = TDATA_W'(res_id);

endmodule

// File: src/gfba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gfba_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 256
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/gfba_ctrl.sv
// Controller state machine of the allocator: sequences pops, pushes,
// group loads and spills. Depends on gfba_pkg.
`timescale 1ns / 1ps

module gfba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  gfba_pkg::dp_stat_t stat_i,
  output gfba_pkg::ctrl_cmd_t cmd_o
);
  import gfba_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (!stat_i.is_free) begin
          state_d = stat_i.cnt_zero ? S_DONE : S_TOP;
        end else if (stat_i.id_bad || !stat_i.cnt_full) begin
          state_d = S_DONE;
        end else begin
          state_d = S_BASE;
        end
      end
      S_TOP: begin
        if (!stat_i.cnt_one || stat_i.top_bad) state_d = S_DONE;
        else state_d = S_BASE;
      end
      S_BASE: begin
        state_d = stat_i.is_free ? S_SPILL : S_LOAD;
      end
      S_LOAD: begin
        if (stat_i.load_last) state_d = S_LOAD_END;
      end
      S_LOAD_END: state_d = S_DONE;
      S_SPILL: begin
        if (stat_i.spill_last) state_d = S_SPILL_END;
      end
      S_SPILL_END: state_d = S_DONE;
      S_DONE: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.res_sel = RES_NONE;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.latch = req_valid_i;
      end
      S_DECODE: begin
        if (!stat_i.is_free) begin
          if (stat_i.cnt_zero) cmd_o.res_sel = RES_FAIL;
        end else if (stat_i.id_bad) begin
          cmd_o.res_sel = RES_ZERO_OK;
        end else if (!stat_i.cnt_full) begin
          cmd_o.push    = 1'b1;
          cmd_o.res_sel = RES_ZERO_OK;
        end else begin
          cmd_o.link_id = 1'b1;
        end
      end
      S_TOP: begin
        if (!stat_i.cnt_one) begin
          cmd_o.pop     = 1'b1;
          cmd_o.res_sel = RES_TOP;
        end else if (stat_i.top_bad) begin
          cmd_o.res_sel = RES_FAIL;
        end else begin
          cmd_o.link_top = 1'b1;
        end
      end
      S_BASE: begin
        cmd_o.calc_base = 1'b1;
        cmd_o.seq_clr   = 1'b1;
      end
      S_LOAD: cmd_o.load_step = 1'b1;
      S_LOAD_END: cmd_o.res_sel = RES_LINK;
      S_SPILL: cmd_o.spill_step = 1'b1;
      S_SPILL_END: begin
        cmd_o.spill_fin = 1'b1;
        cmd_o.res_sel   = RES_ZERO_OK;
      end
      S_DONE: cmd_o.out_load = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: src/gfba_dp.sv
// Datapath of the allocator: stack count, stack RAM, group store RAM,
// copy sequencer and output register. Depends on gfba_pkg and gfba_ram.
`timescale 1ns / 1ps

module gfba_dp #(
  parameter int unsigned GROUP_SIZE = 250,
  parameter int unsigned NUM_BLOCKS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_cmd_i,
  input  logic [gfba_pkg::ID_W-1:0]   req_id_i,
  input  gfba_pkg::ctrl_cmd_t         cmd_i,
  output gfba_pkg::dp_stat_t          stat_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [gfba_pkg::ID_W-1:0]   res_id_o,
  output logic                        res_status_o
);
  import gfba_pkg::*;

  localparam int unsigned REC_WORDS = GROUP_SIZE + 1;
  localparam int unsigned CW  = $clog2(GROUP_SIZE + 1);
  localparam int unsigned AW  = $clog2(GROUP_SIZE);
  localparam int unsigned DDEPTH = NUM_BLOCKS * REC_WORDS;
  localparam int unsigned DAW = $clog2(DDEPTH);
  localparam logic [CW-1:0]  GS_C    = CW'(GROUP_SIZE);
  localparam logic [DAW-1:0] REC_C   = DAW'(REC_WORDS);
  localparam logic [ID_W-1:0] GS_ID  = ID_W'(GROUP_SIZE);

  logic            cmd_q;
  logic [ID_W-1:0] id_q;
  logic [CW-1:0]   count_q, count_d;
  logic            e0_q;
  logic [ID_W-1:0] link_q;
  logic [DAW-1:0]  base_q;
  logic [CW-1:0]   seq_q;
  logic            pv_q;
  logic [CW-1:0]   pidx_q;
  logic [ID_W-1:0] res_id_q;
  logic            res_st_q;
  logic            out_valid_q;
  logic [ID_W-1:0] out_id_q;
  logic            out_st_q;

  logic            stk_we;
  logic [AW-1:0]   stk_waddr, stk_raddr;
  logic [ID_W-1:0] stk_wdata, stk_rdata;
  logic            dsk_we;
  logic [DAW-1:0]  dsk_waddr, dsk_raddr;
  logic [ID_W-1:0] dsk_wdata, dsk_rdata;
  logic [ID_W-1:0] top_val;
  logic [CW-1:0]   sat_cnt;
  logic            pipe_load, pipe_spill;

  // Entry zero reads as the end marker until it is first written.
  assign top_val = (count_q == CW'(1) && e0_q) ? END_MARK : stk_rdata;
  assign sat_cnt = (dsk_rdata > GS_ID) ? GS_C : CW'(dsk_rdata);

  assign pipe_load  = pv_q && (cmd_q == CMD_ALLOC);
  assign pipe_spill = pv_q && (cmd_q == CMD_FREE);

  always_comb begin
    stat_o.is_free    = (cmd_q == CMD_FREE);
    stat_o.cnt_zero   = (count_q == '0);
    stat_o.cnt_one    = (count_q == CW'(1));
    stat_o.cnt_full   = (count_q == GS_C);
    stat_o.id_bad     = (32'(id_q) >= NUM_BLOCKS);
    stat_o.top_bad    = (top_val == END_MARK) || (32'(top_val) >= NUM_BLOCKS);
    stat_o.load_last  = (seq_q == GS_C);
    stat_o.spill_last = (seq_q == GS_C - CW'(1));
    stat_o.out_free   = !out_valid_q || res_ready_i;
  end

  // Stack RAM ports.
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = AW'(count_q);
    stk_wdata = id_q;
    if (cmd_i.push) begin
      stk_we = 1'b1;
    end else if (cmd_i.spill_fin) begin
      stk_we    = 1'b1;
      stk_waddr = '0;
    end else if (pipe_load && pidx_q != '0) begin
      stk_we    = 1'b1;
      stk_waddr = AW'(pidx_q - CW'(1));
      stk_wdata = dsk_rdata;
    end
    stk_raddr = cmd_i.spill_step ? AW'(seq_q) : AW'(count_q - CW'(1));
  end

  // Group store RAM ports.
  always_comb begin
    dsk_we    = 1'b0;
    dsk_waddr = base_q;
    dsk_wdata = ID_W'(count_q);
    if (cmd_i.spill_step && seq_q == '0) begin
      dsk_we = 1'b1;
    end else if (pipe_spill) begin
      dsk_we    = 1'b1;
      dsk_waddr = base_q + DAW'(pidx_q) + DAW'(1);
      // An entry zero never written still holds the end marker.
      dsk_wdata = (pidx_q == '0 && e0_q) ? END_MARK : stk_rdata;
    end
    dsk_raddr = base_q + DAW'(seq_q);
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
    end else if (cmd_i.push) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.spill_fin) begin
      count_d = CW'(1);
    end else if (pipe_load && pidx_q == '0) begin
      count_d = sat_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CW'(1);
      e0_q        <= 1'b1;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (stk_we && stk_waddr == '0) e0_q <= 1'b0;
      pv_q <= cmd_i.load_step || cmd_i.spill_step;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (res_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q <= req_cmd_i;
      id_q  <= req_id_i;
    end
    if (cmd_i.link_id) link_q <= id_q;
    else if (cmd_i.link_top) link_q <= top_val;
    if (cmd_i.calc_base) base_q <= DAW'(link_q) * REC_C;
    if (cmd_i.seq_clr) seq_q <= '0;
    else if (cmd_i.load_step || cmd_i.spill_step) seq_q <= seq_q + CW'(1);
    pidx_q <= seq_q;
    case (cmd_i.res_sel)
      RES_ZERO_OK: begin
        res_id_q <= '0;
        res_st_q <= ST_OK;
      end
      RES_FAIL: begin
        res_id_q <= '0;
        res_st_q <= ST_NONE;
      end
      RES_TOP: begin
        res_id_q <= top_val;
        res_st_q <= ST_OK;
      end
      RES_LINK: begin
        res_id_q <= link_q;
        res_st_q <= ST_OK;
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_id_q <= res_id_q;
      out_st_q <= res_st_q;
    end
  end

  gfba_ram #(
    .WIDTH (ID_W),
    .DEPTH (GROUP_SIZE)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  gfba_ram #(
    .WIDTH (ID_W),
    .DEPTH (DDEPTH)
  ) u_group_ram (
    .clk_i   (clk_i),
    .we_i    (dsk_we),
    .waddr_i (dsk_waddr),
    .wdata_i (dsk_wdata),
    .raddr_i (dsk_raddr),
    .rdata_o (dsk_rdata)
  );

  assign res_valid_o  = out_valid_q;
  assign res_id_o     = out_id_q;
  assign res_status_o = out_st_q;

endmodule

// File: src/gfba_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on gfba_pkg and the allocator assertion macros header.
`timescale 1ns / 1ps
`include "grouped_free_block_allocator_core_macros.svh"

module gfba_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [gfba_pkg::TDATA_W-1:0] m_axis_tdata_o,
  input logic                         m_axis_tuser_o
);
  import gfba_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // Requests accepted but not yet answered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  `GFBA_ASSERT_NEXT(a_hold_result, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result changed while stalled")
  `GFBA_ASSERT_NEXT(a_one_in_work, in_acc, !s_axis_tready_o, "request taken while another is in work")
  `GFBA_ASSERT_NOW(a_fail_zero, m_axis_tvalid_o && m_axis_tuser_o == ST_NONE, m_axis_tdata_o == '0, "failed allocate with nonzero id")
  `GFBA_ASSERT_NOW(a_no_spurious, m_axis_tvalid_o, pend_q != 2'd0, "result without a request")
  `GFBA_ASSERT_NOW(a_pend_bound, 1'b1, pend_q != 2'd3, "too many requests outstanding")

endmodule

bind grouped_free_block_allocator_core gfba_checker u_gfba_checker (.*);
